// ===== design/psf_pkg.sv =====
// Shared types and constants for the prime stream filter.
package psf_pkg;

  // Default parameter values of the top level.
  localparam int CAPACITY_DEF   = 128;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed widths of the result fields.
  localparam int PRIME_W = 16;
  localparam int POS_W   = 7;
  localparam int OUT_TDATA_W = ((PRIME_W + POS_W + 7) / 8) * 8;

  // Quotient bits retired per cycle by the remainder unit.
  localparam int BITS_PER_STEP = 4;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Per-item flags worked out by the front.
  typedef struct packed {
    logic last;     // item closes the current set
    logic trivial;  // value is below 2 and so cannot be prime
  } psf_flags_t;

endpackage

// ===== design/psf_front.sv =====
// Front stage: takes input items, classifies them and hands them to the queue.
module psf_front #(
  parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  logic                    in_last,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [VALUE_BITS-1:0]   push_value,
  output psf_pkg::psf_flags_t     push_flags
);
  import psf_pkg::*;

  logic                  held;
  logic [VALUE_BITS-1:0] value;
  psf_flags_t            flags;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_value = value;
  assign push_flags = flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  // A value of 0 or 1 has no bits set above bit 0.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value         <= in_value;
      flags.last    <= in_last;
      flags.trivial <= (in_value[VALUE_BITS-1:1] == '0);
    end
  end

endmodule

// ===== design/psf_queue.sv =====
// Short first-in first-out queue between the front and the back.
module psf_queue #(
  parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  logic [VALUE_BITS-1:0]   push_value,
  input  psf_pkg::psf_flags_t     push_flags,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output logic [VALUE_BITS-1:0]   pop_value,
  output psf_pkg::psf_flags_t     pop_flags
);
  import psf_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = VALUE_BITS + $bits(psf_flags_t);

  logic [EW-1:0] entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != CW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_value  = entries[rd_ptr][VALUE_BITS-1:0];
  assign pop_flags  = psf_flags_t'(entries[rd_ptr][EW-1:VALUE_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= {push_flags, push_value};
    end
  end

endmodule

// ===== design/psf_back.sv =====
// Back stage: trial division over a shared remainder unit, set counter and result register.
module psf_back #(
  parameter int CAPACITY   = psf_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [VALUE_BITS-1:0]             pop_value,
  input  psf_pkg::psf_flags_t               pop_flags,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [psf_pkg::OUT_TDATA_W-1:0]   out_data
);
  import psf_pkg::*;

  localparam int DW        = (VALUE_BITS + 1) / 2 + 2;
  localparam int RW        = DW + 1;
  localparam int SQW       = VALUE_BITS + 2;
  localparam int DIV_STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PADW      = DIV_STEPS * BITS_PER_STEP;
  localparam int SW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CW        = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TEST = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } psf_state_t;

  psf_state_t            state;
  logic [VALUE_BITS-1:0] value;
  logic                  last;
  logic [DW-1:0]         divisor;
  logic [SQW-1:0]        square;
  logic [RW-1:0]         rem;
  logic [PADW-1:0]       shifter;
  logic [SW-1:0]         step;
  logic                  is_prime;
  logic [CW-1:0]         count;
  logic [RW-1:0]         rem_next;
  logic                  slot_free;
  logic                  emit;

  // Four restoring remainder steps, most significant dividend bit first.
  always_comb begin
    logic [RW-1:0] r;
    r = rem;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {r[DW-1:0], shifter[PADW-1-i]};
      if (r >= RW'(divisor)) begin
        r = r - RW'(divisor);
      end
    end
    rem_next = r;
  end

  assign pop_ready = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign emit      = is_prime && (count < CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= pop_flags.trivial ? ST_DONE : ST_TEST;
          end
        end
        ST_TEST: begin
          state <= (square > SQW'(value)) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (step == SW'(DIV_STEPS - 1)) begin
            state <= (rem_next == '0) ? ST_DONE : ST_TEST;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
            if (last) begin
              count <= '0;
            end else if (emit) begin
              count <= count + CW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          value    <= pop_value;
          last     <= pop_flags.last;
          divisor  <= DW'(2);
          square   <= SQW'(4);
          is_prime <= 1'b0;
        end
      end
      ST_TEST: begin
        if (square > SQW'(value)) begin
          is_prime <= 1'b1;
        end else begin
          rem     <= '0;
          shifter <= PADW'(value);
          step    <= '0;
        end
      end
      ST_DIV: begin
        rem     <= rem_next;
        shifter <= shifter << BITS_PER_STEP;
        step    <= step + SW'(1);
        if (step == SW'(DIV_STEPS - 1) && rem_next != '0) begin
          // (d+1)^2 = d^2 + 2d + 1
          divisor <= divisor + DW'(1);
          square  <= square + SQW'({divisor, 1'b1});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free && emit) begin
      out_data <= OUT_TDATA_W'({POS_W'(count), PRIME_W'(value)});
    end
  end

endmodule

// ===== design/prime_stream_filter.sv =====
// Top level of the prime stream filter: front, queue and trial-division back end.
//
// The block reads candidate values on the s_axis channel and passes on the primes
// among them on the m_axis channel, each with its position among the primes kept
// so far in the current set. s_axis_tlast marks the last item of a set; the
// position count starts again at zero after it. Once CAPACITY primes are kept in
// one set, further primes of that set are dropped and produce no item.
// An item is held in the front register, then waits in a two-entry queue until
// the back end is free. The back end tries divisors 2, 3, ... while the divisor
// squared is at most the value and none has divided it; for each divisor it does
// the bound check and then a pass through the remainder unit, which retires four
// quotient bits per cycle. A 16-bit prime takes up to 254 divisors; 0 and 1 skip
// the divisor tests. The back end takes no new item until it is through with the
// current one; the front and queue absorb up to three items meanwhile. The result
// sits in an output register; while the receiver holds m_axis_tready low the back
// end waits with the next result and the front fills, then s_axis_tready drops.
// Reset empties the queue and output and zeroes the count.
module prime_stream_filter #(
  parameter int CAPACITY   = psf_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // value
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // last_of_set
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // prime_value [15:0], position [22:16], zero padding above
  output logic [psf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import psf_pkg::*;

  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_value;
  psf_flags_t            push_flags;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [VALUE_BITS-1:0] pop_value;
  psf_flags_t            pop_flags;

  // Bits of tdata above VALUE_BITS are padding and are ignored.
  psf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata[VALUE_BITS-1:0]),
    .in_last    (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_flags (push_flags)
  );

  psf_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_flags (push_flags),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_value  (pop_value),
    .pop_flags  (pop_flags)
  );

  psf_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_value (pop_value),
    .pop_flags (pop_flags),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // Values 0 and 1 are never passed on as primes.
  a_no_trivial: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[PRIME_W-1:1] != '0))
    else $error("value below 2 emitted as prime");

  // The only even prime is 2.
  a_odd_or_two: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] || (m_axis_tdata[PRIME_W-1:0] == PRIME_W'(2))))
    else $error("even value other than 2 emitted as prime");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for the prime stream filter: edge values, set capacity, back-pressure and random streams.
module tb;
  import psf_pkg::*;

  localparam int CLK_HIGH = 6;
  localparam int CLK_LOW  = 6;
  localparam int IN_W     = ((VALUE_BITS_DEF + 7) / 8) * 8;
  localparam int SET_CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 2000;
  // Up to four composite items may still sit in the block once nothing is pending,
  // and SETTLE_CYCLES gives the back end time to work through them.
  localparam int SETTLE_CYCLES = 6000;
  localparam longint LIMIT_CYCLES = 12_000_000;

  typedef struct packed {
    logic [PRIME_W-1:0] prime_value;
    logic [POS_W-1:0]   position;
  } prime_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  prime_result_t pending_primes[$];
  int unsigned   kept_in_set = 0;
  int unsigned   error_count = 0;
  int            burst_left = 0;
  bit            sender_gaps = 1'b0;
  int unsigned   hold_off_cycles = 0;
  longint        cycle_count = 0;

  prime_stream_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #CLK_LOW clk = 1'b1;
    #CLK_HIGH clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit is_prime_value(int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned prime_at_or_above(int unsigned v);
    while (!is_prime_value(v)) v++;
    return v;
  endfunction

  // Primes past the capacity of a set are dropped; tlast restarts the count.
  function automatic void predict_item(logic [IN_W-1:0] value, logic last);
    prime_result_t res;
    if (is_prime_value(32'(value[VALUE_BITS_DEF-1:0])) && kept_in_set < SET_CAPACITY) begin
      res.prime_value = PRIME_W'(value);
      res.position    = POS_W'(kept_in_set);
      pending_primes.push_back(res);
      kept_in_set++;
    end
    if (last) kept_in_set = 0;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Inputs are predicted before outputs are checked, both on the same edge.
  always @(posedge clk) begin : check_results
    prime_result_t seen;
    prime_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.prime_value = m_axis_tdata[PRIME_W-1:0];
        seen.position    = m_axis_tdata[PRIME_W +: POS_W];
        if (pending_primes.size() == 0) begin
          report_mismatch($sformatf("unexpected item: prime %0d position %0d",
                                    seen.prime_value, seen.position));
        end else begin
          want = pending_primes.pop_front();
          if (seen.prime_value !== want.prime_value)
            report_mismatch($sformatf("prime_value %0d, expected %0d",
                                      seen.prime_value, want.prime_value));
          if (seen.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d for prime %0d",
                                      seen.position, want.position, want.prime_value));
        end
      end
    end
  end

  // Receiver: picks a new random stall mode whenever the current one runs out; a hold-off wins over all.
  initial begin : receiver
    int     mode;
    int     mode_left;
    longint tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= tick[3];
        endcase
      end
    end
  end

  task automatic send_item(input logic [IN_W-1:0] value, input logic last);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (sender_gaps)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 400) : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IN_W'($urandom_range(0, 255));
      4, 5:       return IN_W'($urandom_range(0, 4095));
      6, 7:       return IN_W'($urandom);
      8:          return IN_W'(prime_at_or_above($urandom_range(2, 2000)));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return IN_W'(1);
          2: return IN_W'(65521);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Values at the field extremes, the bound check on exact squares, and tlast
  // on prime and non-prime items.
  task automatic test_edge_values();
    sender_gaps = 1'b0;
    send_item(IN_W'(0), 1'b0);
    send_item(IN_W'(1), 1'b0);
    send_item(IN_W'(2), 1'b0);
    send_item(IN_W'(3), 1'b0);
    send_item(IN_W'(4), 1'b0);
    send_item(IN_W'(1), 1'b1);
    send_item(IN_W'(65521), 1'b0);
    send_item(IN_W'(65535), 1'b0);
    send_item(IN_W'(63001), 1'b0);
    send_item(IN_W'(49), 1'b0);
    send_item(IN_W'(32768), 1'b0);
    send_item(IN_W'(21845), 1'b0);
    send_item(IN_W'(43690), 1'b0);
    send_item(IN_W'(65521), 1'b1);
    send_item(IN_W'(2), 1'b0);
    send_item(IN_W'(7), 1'b0);
    send_item(IN_W'(251), 1'b1);
    send_item(IN_W'(65534), 1'b0);
    send_item(IN_W'(9), 1'b1);
    wait_until_drained();
  endtask

  task automatic test_set_capacity();
    int unsigned p;
    int          i;
    sender_gaps = 1'b1;
    // Overrun the set; the closing item is a dropped prime that still resets the count.
    p = 2;
    for (i = 0; i < SET_CAPACITY + 8; i++) begin
      send_item(IN_W'(p), i == SET_CAPACITY + 7);
      p = prime_at_or_above(p + 1);
    end
    // Exactly a full set, closed by a composite item.
    p = 2;
    for (i = 0; i < SET_CAPACITY; i++) begin
      send_item(IN_W'(p), 1'b0);
      p = prime_at_or_above(p + 1);
    end
    send_item(IN_W'(4), 1'b1);
    send_item(IN_W'(3), 1'b0);
    send_item(IN_W'(5), 1'b1);
    wait_until_drained();
  endtask

  // Fast primes against a long receiver hold-off: the block fills and stalls its input.
  task automatic test_output_backpressure();
    int unsigned p;
    int          i;
    sender_gaps = 1'b0;
    hold_off_cycles = 3000;
    p = 2;
    for (i = 0; i < 12; i++) begin
      send_item(IN_W'(p), i == 11);
      p = prime_at_or_above(p + 1);
    end
    wait_until_drained();
  endtask

  task automatic test_random_stream();
    int              sent;
    int              set_len;
    int              i;
    bit              prime_run;
    int unsigned     p;
    logic [IN_W-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      prime_run = ($urandom_range(0, 15) == 0);
      p = prime_at_or_above($urandom_range(2, 200));
      if (prime_run) set_len = $urandom_range(SET_CAPACITY - 4, SET_CAPACITY + 20);
      else set_len = $urandom_range(1, 40);
      for (i = 0; i < set_len; i++) begin
        if (prime_run) begin
          v = IN_W'(p);
          p = prime_at_or_above(p + 1);
        end else begin
          v = random_value();
        end
        send_item(v, i == set_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_set_capacity();
    test_output_backpressure();
    test_random_stream();
    wait_until_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/psf_pkg.sv
design/psf_front.sv
design/psf_queue.sv
design/psf_back.sv
design/prime_stream_filter.sv
dv/tb.sv
